>>> hw/rtl/cph_pkg.sv
package cph_pkg;

  // histogram geometry
  localparam int SLICES     = 6;
  localparam int RINGS      = 5;
  localparam int SECTORS    = 8;
  localparam int COUNT_BITS = 16;

  localparam int NBINS     = SLICES * RINGS * SECTORS;
  localparam int RING_SECT = RINGS * SECTORS;
  localparam int ADDR_W    = $clog2(NBINS);
  localparam int SLICE_W   = (SLICES > 1) ? $clog2(SLICES) : 1;
  localparam int RING_W    = (RINGS > 1) ? $clog2(RINGS) : 1;
  localparam int SECT_W    = $clog2(SECTORS);

  // field widths
  localparam int COORD_W     = 24;
  localparam int SLICE_H_W   = 23;
  localparam int RING_STEP_W = 48;
  localparam int SEL_W       = 8;
  localparam int FRAC_BITS   = 16;
  localparam int SQ_W        = 2 * COORD_W;

  localparam int SLICE_THR_W = SLICE_H_W + $clog2(SLICES + 1);
  localparam int RING_THR_W  = RING_STEP_W + $clog2(RINGS + 1);

  localparam int MAX_DIM   = (SLICES > RINGS) ? SLICES : RINGS;
  localparam int BIN_ITERS = (MAX_DIM > 1) ? MAX_DIM - 1 : 1;
  localparam int MAX_STEPS = (BIN_ITERS > FRAC_BITS) ? BIN_ITERS : FRAC_BITS;
  localparam int STEP_W    = $clog2(MAX_STEPS + 1);

  localparam logic [FRAC_BITS:0] FRAC_ONE = {1'b1, {FRAC_BITS{1'b0}}};

  // configuration port
  localparam int PADDR_W      = 5;
  localparam int PDATA_W      = 64;
  localparam int REG_ADDR_LSB = 3;
  localparam int REG_IDX_W    = PADDR_W - REG_ADDR_LSB;

  typedef enum logic [1:0] {
    FUNC_CLEAR = 2'd0,
    FUNC_ADD   = 2'd1,
    FUNC_READ  = 2'd2
  } func_e;

  typedef enum logic [REG_IDX_W-1:0] {
    REG_BASE_HEIGHT  = 2'd0,
    REG_SLICE_HEIGHT = 2'd1,
    REG_RING_STEP    = 2'd2
  } cfg_reg_e;

  typedef enum logic [3:0] {
    S_IDLE,
    S_SQUARE,
    S_SUM,
    S_BIN,
    S_ADD_RD,
    S_ADD_WR,
    S_RD_BIN,
    S_DIV_INIT,
    S_DIV,
    S_RESULT
  } state_e;

  typedef struct packed {
    func_e                      func;
    logic signed [COORD_W-1:0]  point_x;
    logic signed [COORD_W-1:0]  point_y;
    logic signed [COORD_W-1:0]  point_z;
    logic [SEL_W-1:0]           bin_select;
  } in_item_t;

  typedef struct packed {
    logic [FRAC_BITS:0]    bin_fraction;
    logic [COUNT_BITS-1:0] bin_count;
    logic [COUNT_BITS-1:0] point_total;
    logic                  count_overflow;
  } out_item_t;

  typedef struct packed {
    logic signed [COORD_W-1:0] base_height;
    logic [SLICE_H_W-1:0]      slice_height;
    logic [RING_STEP_W-1:0]    ring_step;
  } cfg_t;

  typedef struct packed {
    logic capture;
    logic clear;
    logic square;
    logic sum;
    logic bin_step;
    logic rd_sel;
    logic wr_add;
    logic div_init;
    logic div_step;
    logic out_load;
  } dp_cmd_t;

  typedef struct packed {
    logic out_full;
  } dp_sts_t;

endpackage

>>> hw/rtl/cph_regs.sv
module cph_regs import cph_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [PADDR_W-1:0] paddr,
  input  logic [PDATA_W-1:0] pwdata,
  output logic [PDATA_W-1:0] prdata,
  output logic               pready,
  output cfg_t               cfg_o
);

  cfg_t     cfg_q, cfg_d;
  cfg_reg_e reg_idx;
  logic     wr_en;

  assign pready  = 1'b1;
  assign reg_idx = cfg_reg_e'(paddr[PADDR_W-1:REG_ADDR_LSB]);
  assign wr_en   = psel && penable && pwrite;

  always_comb begin
    cfg_d = cfg_q;
    if (wr_en) begin
      case (reg_idx)
        REG_BASE_HEIGHT:  cfg_d.base_height  = pwdata[COORD_W-1:0];
        REG_SLICE_HEIGHT: cfg_d.slice_height = pwdata[SLICE_H_W-1:0];
        REG_RING_STEP:    cfg_d.ring_step    = pwdata[RING_STEP_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_idx)
      REG_BASE_HEIGHT: begin
        prdata = {{(PDATA_W-COORD_W){cfg_q.base_height[COORD_W-1]}}, cfg_q.base_height};
      end
      REG_SLICE_HEIGHT: prdata = {{(PDATA_W-SLICE_H_W){1'b0}}, cfg_q.slice_height};
      REG_RING_STEP:    prdata = {{(PDATA_W-RING_STEP_W){1'b0}}, cfg_q.ring_step};
      default:          prdata = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.base_height  <= '0;
      cfg_q.slice_height <= SLICE_H_W'(65536);
      cfg_q.ring_step    <= RING_STEP_W'(64'd4294967296);
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

>>> hw/rtl/cph_ctrl.sv
module cph_ctrl import cph_pkg::*; (
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    in_valid_i,
  input  func_e   in_func_i,
  output logic    in_stall_o,
  output dp_cmd_t cmd_o,
  input  dp_sts_t sts_i
);

  state_e            state_q, state_d;
  logic [STEP_W-1:0] step_q, step_d;

  always_comb begin
    state_d    = state_q;
    step_d     = step_q;
    cmd_o      = '0;
    in_stall_o = 1'b1;
    case (state_q)
      S_IDLE: begin
        in_stall_o = 1'b0;
        if (in_valid_i) begin
          cmd_o.capture = 1'b1;
          case (in_func_i)
            FUNC_CLEAR: cmd_o.clear = 1'b1;
            FUNC_ADD:   state_d = S_SQUARE;
            FUNC_READ:  state_d = S_RD_BIN;
            default: ;
          endcase
        end
      end
      S_SQUARE: begin
        cmd_o.square = 1'b1;
        state_d      = S_SUM;
      end
      S_SUM: begin
        cmd_o.sum = 1'b1;
        step_d    = STEP_W'(BIN_ITERS - 1);
        state_d   = S_BIN;
      end
      // one threshold compare per cycle for slice and ring
      S_BIN: begin
        cmd_o.bin_step = 1'b1;
        if (step_q == '0) begin
          state_d = S_ADD_RD;
        end else begin
          step_d = step_q - 1'b1;
        end
      end
      S_ADD_RD: state_d = S_ADD_WR;
      S_ADD_WR: begin
        cmd_o.wr_add = 1'b1;
        state_d      = S_IDLE;
      end
      S_RD_BIN: begin
        cmd_o.rd_sel = 1'b1;
        state_d      = S_DIV_INIT;
      end
      S_DIV_INIT: begin
        cmd_o.div_init = 1'b1;
        step_d         = STEP_W'(FRAC_BITS - 1);
        state_d        = S_DIV;
      end
      S_DIV: begin
        cmd_o.div_step = 1'b1;
        if (step_q == '0) begin
          state_d = S_RESULT;
        end else begin
          step_d = step_q - 1'b1;
        end
      end
      S_RESULT: begin
        if (!sts_i.out_full) begin
          cmd_o.out_load = 1'b1;
          state_d        = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      step_q  <= '0;
    end else begin
      state_q <= state_d;
      step_q  <= step_d;
    end
  end

endmodule

>>> hw/rtl/cph_dp.sv
module cph_dp import cph_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  dp_cmd_t   cmd_i,
  output dp_sts_t   sts_o,
  input  in_item_t  in_data_i,
  input  cfg_t      cfg_i,
  input  logic      out_stall_i,
  output logic      out_valid_o,
  output out_item_t out_data_o
);

  function automatic logic [SECT_W-1:0] pick_sector(
    input logic signed [COORD_W-1:0] x,
    input logic signed [COORD_W-1:0] y,
    input logic [COORD_W-1:0]        ax,
    input logic [COORD_W-1:0]        ay
  );
    logic [SECT_W-1:0] s;
    if (y == '0) begin
      s = (x < 0) ? SECT_W'(0) : SECT_W'(4);
    end else if (y > 0) begin
      if (x > 0) s = (ay < ax) ? SECT_W'(4) : SECT_W'(5);
      else       s = (ax < ay) ? SECT_W'(6) : SECT_W'(7);
    end else if (x < 0) begin
      s = (ay < ax) ? SECT_W'(0) : SECT_W'(1);
    end else if (x == '0) begin
      s = SECT_W'(2);
    end else begin
      s = (ay > ax) ? SECT_W'(2) : SECT_W'(3);
    end
    return s;
  endfunction

  // captured beat
  logic signed [COORD_W-1:0] x_q, y_q, z_q;
  logic [SEL_W-1:0]          sel_q;

  // binning
  logic [COORD_W-1:0]     ax, ay;
  logic [SQ_W-1:0]        sqx_q, sqy_q, r2_q;
  logic signed [COORD_W:0] h_q;
  logic [SECT_W-1:0]      sector_q;
  logic [SLICE_W-1:0]     slice_q;
  logic [RING_W-1:0]      ring_q;
  logic [SLICE_THR_W-1:0] sthr_q;
  logic [RING_THR_W-1:0]  rthr_q;
  logic                   slice_go, ring_go;
  logic [ADDR_W-1:0]      idx;

  // bin store
  logic [COUNT_BITS-1:0] bin_mem [NBINS];
  logic [NBINS-1:0]      vld_q;
  logic [COUNT_BITS-1:0] rd_q;
  logic                  rd_hit_q;
  logic [ADDR_W-1:0]     raddr;
  logic                  sel_in_range, hit;
  logic [COUNT_BITS-1:0] cur_cnt, inc_cnt;
  logic                  cnt_sat, tot_sat;
  logic [COUNT_BITS-1:0] points_q;
  logic                  flag_q;

  // fraction divider
  logic [COUNT_BITS:0]   rem_q, rem_shl;
  logic [FRAC_BITS-1:0]  quo_q;
  logic [COUNT_BITS-1:0] cnt_q;
  logic                  none_q, full_q, rem_ge;
  logic [FRAC_BITS:0]    frac;

  out_item_t out_q;
  logic      out_vld_q;

  assign ax = x_q[COORD_W-1] ? COORD_W'(-x_q) : COORD_W'(x_q);
  assign ay = y_q[COORD_W-1] ? COORD_W'(-y_q) : COORD_W'(y_q);

  assign slice_go = !h_q[COORD_W] && (slice_q < SLICE_W'(SLICES - 1)) &&
                    (SLICE_THR_W'(h_q[COORD_W-1:0]) >= sthr_q);
  assign ring_go  = (ring_q < RING_W'(RINGS - 1)) && (RING_THR_W'(r2_q) >= rthr_q);

  assign idx = ADDR_W'(int'(slice_q) * RING_SECT + int'(ring_q) * SECTORS + int'(sector_q));

  assign sel_in_range = int'(sel_q) < NBINS;
  assign raddr        = cmd_i.rd_sel ? ADDR_W'(sel_q) : idx;
  assign hit          = cmd_i.rd_sel ? sel_in_range : 1'b1;

  // entries never written since clear read as zero
  assign cur_cnt = rd_hit_q ? rd_q : '0;
  assign cnt_sat = &cur_cnt;
  assign inc_cnt = cnt_sat ? cur_cnt : cur_cnt + 1'b1;
  assign tot_sat = &points_q;

  assign rem_shl = {rem_q[COUNT_BITS-1:0], 1'b0};
  assign rem_ge  = rem_shl >= {1'b0, points_q};

  assign frac = none_q ? '0 : (full_q ? FRAC_ONE : {1'b0, quo_q});

  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      x_q   <= in_data_i.point_x;
      y_q   <= in_data_i.point_y;
      z_q   <= in_data_i.point_z;
      sel_q <= in_data_i.bin_select;
    end
    if (cmd_i.square) begin
      sqx_q    <= ax * ax;
      sqy_q    <= ay * ay;
      h_q      <= (COORD_W+1)'(z_q) - (COORD_W+1)'(cfg_i.base_height);
      sector_q <= pick_sector(x_q, y_q, ax, ay);
    end
    if (cmd_i.sum) begin
      r2_q    <= sqx_q + sqy_q;
      slice_q <= '0;
      ring_q  <= '0;
      sthr_q  <= SLICE_THR_W'(cfg_i.slice_height);
      rthr_q  <= RING_THR_W'(cfg_i.ring_step);
    end
    if (cmd_i.bin_step) begin
      if (slice_go) begin
        slice_q <= slice_q + 1'b1;
        sthr_q  <= sthr_q + SLICE_THR_W'(cfg_i.slice_height);
      end
      if (ring_go) begin
        ring_q <= ring_q + 1'b1;
        rthr_q <= rthr_q + RING_THR_W'(cfg_i.ring_step);
      end
    end
    if (cmd_i.div_init) begin
      cnt_q  <= cur_cnt;
      rem_q  <= {1'b0, cur_cnt};
      quo_q  <= '0;
      none_q <= points_q == '0;
      full_q <= cur_cnt >= points_q;
    end
    if (cmd_i.div_step) begin
      rem_q <= rem_ge ? rem_shl - {1'b0, points_q} : rem_shl;
      quo_q <= {quo_q[FRAC_BITS-2:0], rem_ge};
    end
    if (cmd_i.out_load) begin
      out_q.bin_fraction   <= frac;
      out_q.bin_count      <= cnt_q;
      out_q.point_total    <= points_q;
      out_q.count_overflow <= flag_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.wr_add) begin
      bin_mem[idx] <= inc_cnt;
    end
    rd_q <= bin_mem[raddr];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q     <= '0;
      rd_hit_q  <= 1'b0;
      points_q  <= '0;
      flag_q    <= 1'b0;
      out_vld_q <= 1'b0;
    end else begin
      rd_hit_q <= hit && vld_q[raddr];
      if (cmd_i.clear) begin
        vld_q    <= '0;
        points_q <= '0;
        flag_q   <= 1'b0;
      end else if (cmd_i.wr_add) begin
        vld_q[idx] <= 1'b1;
        points_q   <= tot_sat ? points_q : points_q + 1'b1;
        flag_q     <= flag_q | cnt_sat | tot_sat;
      end
      if (cmd_i.out_load) begin
        out_vld_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_vld_q <= 1'b0;
      end
    end
  end

  assign sts_o.out_full = out_vld_q && out_stall_i;
  assign out_valid_o    = out_vld_q;
  assign out_data_o     = out_q;

endmodule

>>> hw/rtl/cylindrical_point_histogram.sv
// channel | direction | handshake             | beat
// in      | input     | in_valid_i/in_stall_o | in_item_t: func, point xyz, bin_select
// out     | output    | out_valid_o/out_stall_i | out_item_t: fraction, count, total, flag
// cfg     | input     | apb psel/penable      | 64-bit registers at 8*i
//
// clear empties the store; add runs squares, sum, one threshold step per cycle for
// slice and ring, then read and write of the bin ram
// read runs a bin ram read, then a bit-serial divider for the fraction
// only one beat is in flight; in_stall_o is high until the controller returns to idle
// a finished read waits in the output register while out_stall_i is high
// reset empties the store at once through per-bin valid bits and loads register defaults
module cylindrical_point_histogram import cph_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  in_item_t           in_data_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output out_item_t          out_data_o,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [PADDR_W-1:0] paddr,
  input  logic [PDATA_W-1:0] pwdata,
  output logic [PDATA_W-1:0] prdata,
  output logic               pready
);

  cfg_t    cfg;
  dp_cmd_t cmd;
  dp_sts_t sts;

  cph_regs u_regs (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  cph_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_func_i  (in_data_i.func),
    .in_stall_o (in_stall_o),
    .cmd_o      (cmd),
    .sts_i      (sts)
  );

  cph_dp u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd),
    .sts_o       (sts),
    .in_data_i   (in_data_i),
    .cfg_i       (cfg),
    .out_stall_i (out_stall_i),
    .out_valid_o (out_valid_o),
    .out_data_o  (out_data_o)
  );

endmodule
